FILE: sv/zors_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zors_pkg
// Shared types and constants for the surface stacking-order list.
// ----------------------------------------------------------------------------
package zors_pkg;

    localparam int ID_W    = 32;
    localparam int RANK_W  = 5;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_RAISE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [RANK_W-1:0] RANK_ABSENT = '1;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic cmp_en;   // capture compare result this cycle
        logic live;     // cell lies below the current count
        logic shift;    // take the entry of the cell above
        logic load;     // take the broadcast identity
        logic clear;    // drop to the cleared identity
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } t_state;

endpackage

FILE: sv/zors_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zors_cell
// One slot of the stacking list: holds an identity, compares it against the
// broadcast identity, shifts down from its upper neighbor on a delete, and loads or clears.
// ----------------------------------------------------------------------------
module zors_cell (
    input  logic                     i_clk,
    input  zors_pkg::t_cell_ctl      i_ctl,
    input  logic [zors_pkg::ID_W-1:0] i_id,
    input  logic [zors_pkg::ID_W-1:0] i_up_entry,
    output logic [zors_pkg::ID_W-1:0] o_entry,
    output logic                     o_hit
);

    logic [zors_pkg::ID_W-1:0] r_entry;
    logic                      r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_hit <= i_ctl.live && (r_entry == i_id);
        end
        // hold unless told to move
        if (i_ctl.shift) begin
            r_entry <= i_up_entry;
        end else if (i_ctl.load) begin
            r_entry <= i_id;
        end else if (i_ctl.clear) begin
            r_entry <= '0;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

FILE: sv/zors_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zors_rank
// Encode the at-most-one-hot match vector of the cell row into a position.
// ----------------------------------------------------------------------------
module zors_rank #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic [N-1:0]  i_hits,
    output logic          o_found,
    output logic [IW-1:0] o_rank
);

    // Hits are unique, so an OR of the selected indices is the position.
    always_comb begin
        o_rank = '0;
        for (int i = 0; i < N; i++) begin
            if (i_hits[i]) begin
                o_rank = o_rank | IW'(i);
            end
        end
    end

    assign o_found = |i_hits;

endmodule

FILE: sv/z_order_raise_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_order_raise_stack
// Stacking-order list of surface identities with raise, remove and rank query.
// ----------------------------------------------------------------------------
// Each beat is accepted on start while busy is low, and busy then
// stays high for exactly one cycle. In the accept cycle every cell compares
// its identity with i_surface_id and registers the hit; in the following
// cycle the hit position is encoded, the row of cells shifts, loads or clears
// in one step, and the result is registered. o_done rises at the same edge
// at which busy falls and holds the result fields for that one cycle; it
// cannot be stalled: sample it when o_done is high. A new start may be given
// in the same cycle as o_done. The list length is MAX_SURFACES; rank and count
// wrap to their 5-bit fields beyond 16 and 31 entries respectively.
// ----------------------------------------------------------------------------
module z_order_raise_stack #(
    parameter int MAX_SURFACES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [zors_pkg::CMD_W-1:0]            i_cmd,
    input  logic [zors_pkg::ID_W-1:0]             i_surface_id,
    output logic                                  o_done,
    output logic signed [zors_pkg::RANK_W-1:0]    o_rank_before,
    output logic [zors_pkg::COUNT_W-1:0]          o_count_after,
    output logic                                  o_changed
);

    localparam int IW = $clog2(MAX_SURFACES);
    localparam int CW = $clog2(MAX_SURFACES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SURFACES);

    zors_pkg::t_state          r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [zors_pkg::CMD_W-1:0] r_cmd;
    logic [zors_pkg::ID_W-1:0] r_id;
    logic                      r_done;
    logic [zors_pkg::RANK_W-1:0]  r_rank_before, n_rank_before;
    logic [zors_pkg::COUNT_W-1:0] r_count_after;
    logic                      r_changed, n_changed;

    logic                      w_accept;
    logic                      w_apply;
    logic [zors_pkg::ID_W-1:0] w_bus_id;
    logic [MAX_SURFACES-1:0]   w_hits;
    logic                      w_found;
    logic [IW-1:0]             w_rank;
    logic [CW-1:0]             w_rank_c;
    logic [CW-1:0]             w_top;

    // Operation decode for the apply cycle.
    logic w_del;       // remove the found entry and close the gap
    logic w_to_top;    // after the delete, write the identity at the new top
    logic w_append;    // absent surface, room left: write above the top
    logic w_zap;       // plain remove: clear the vacated top slot

    logic [zors_pkg::ID_W-1:0] w_entry [MAX_SURFACES];
    zors_pkg::t_cell_ctl       w_ctl   [MAX_SURFACES];

    assign busy     = (r_state == zors_pkg::ST_APPLY);
    assign w_accept = start && !busy;
    assign w_apply  = (r_state == zors_pkg::ST_APPLY);
    assign w_bus_id = w_apply ? r_id : i_surface_id;

    zors_rank #(
        .N  (MAX_SURFACES),
        .IW (IW)
    ) u_rank (
        .i_hits  (w_hits),
        .o_found (w_found),
        .o_rank  (w_rank)
    );

    assign w_rank_c = CW'(w_rank);
    assign w_top    = r_count - CW'(1);

    always_comb begin
        w_del    = 1'b0;
        w_to_top = 1'b0;
        w_append = 1'b0;
        w_zap    = 1'b0;
        case (r_cmd)
            zors_pkg::CMD_REMOVE: begin
                w_del = w_found;
                w_zap = w_found;
            end
            zors_pkg::CMD_RAISE: begin
                // already on top: leave the list alone
                if (w_found && (w_rank_c != w_top)) begin
                    w_del    = 1'b1;
                    w_to_top = 1'b1;
                end else if (!w_found && (r_count < MAX_CNT)) begin
                    w_append = 1'b1;
                end
            end
            default: begin
                // query, and the unused code, leave the list alone
            end
        endcase
    end

    // Row of cells: each takes its upper neighbor's entry on a shift; the last cell's neighbor input is zero.
    for (genvar g = 0; g < MAX_SURFACES; g++) begin : g_cell
        localparam logic [CW-1:0] POS = CW'(g);

        always_comb begin
            w_ctl[g].cmp_en = w_accept;
            w_ctl[g].live   = (POS < r_count);
            w_ctl[g].shift  = w_apply && w_del && (POS >= w_rank_c) && (POS < w_top);
            w_ctl[g].load   = w_apply && ((w_to_top && (POS == w_top)) ||
                                          (w_append && (POS == r_count)));
            w_ctl[g].clear  = w_apply && w_zap && (POS == w_top);
        end

        if (g == MAX_SURFACES - 1) begin : g_last
            zors_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_id       (w_bus_id),
                .i_up_entry ('0),
                .o_entry    (w_entry[g]),
                .o_hit      (w_hits[g])
            );
        end else begin : g_mid
            zors_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_id       (w_bus_id),
                .i_up_entry (w_entry[g+1]),
                .o_entry    (w_entry[g]),
                .o_hit      (w_hits[g])
            );
        end
    end

    // Next count and result fields.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rank_before = w_found ? zors_pkg::RANK_W'(w_rank) : zors_pkg::RANK_ABSENT;
        n_changed     = w_del || w_append;
        case (r_state)
            zors_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = zors_pkg::ST_APPLY;
                end
            end
            zors_pkg::ST_APPLY: begin
                n_state = zors_pkg::ST_IDLE;
                if (w_zap) begin
                    n_count = w_top;
                end else if (w_append) begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                n_state = zors_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zors_pkg::ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= w_apply;
        end
    end

    // Payload: capture the beat, then the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_id  <= i_surface_id;
        end
        if (w_apply) begin
            r_rank_before <= n_rank_before;
            r_count_after <= zors_pkg::COUNT_W'(n_count);
            r_changed     <= n_changed;
        end
    end

    assign o_done        = r_done;
    assign o_rank_before = $signed(r_rank_before);
    assign o_count_after = r_count_after;
    assign o_changed     = r_changed;

`ifndef SYNTHESIS
    // Live identities are unique, so at most one cell can hit.
    a_hits_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |-> $onehot0(w_hits))
        else $error("more than one cell matched the identity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("list count beyond capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_done)
        else $error("accepted beat produced no result");

    a_done_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && (r_state == zors_pkg::ST_IDLE))
        else $error("result strobe while still applying");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the surface stacking-order list.
// ----------------------------------------------------------------------------
// Drives raise, remove and rank-query beats through the start/busy handshake.
// A scoreboard keeps its own copy of the stacking order and predicts each
// result; every o_done strobe is compared field by field with the oldest
// prediction. A short directed run covers these corners:
//   - query, remove and raise on an empty list
//   - raise of the surface already on top
//   - identity zero and the all-ones identity
//   - the spare command code
//   - a full list
//   - removal at the bottom, middle and top
// Random traffic then draws most identities from a small pool, so hits,
// moves and removals are frequent.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_SURF      = 16;
    localparam int N_RANDOM    = 1400;
    localparam int POOL_SIZE   = 20;
    localparam int STALL_MAX   = 1000;
    localparam int TAIL_CYCLES = 4;
    localparam int REPORT_MAX  = 10;

    // Unused command code; the block treats it as a rank query.
    localparam logic [zors_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic signed [zors_pkg::RANK_W-1:0] rank_before;
        logic [zors_pkg::COUNT_W-1:0]       count_after;
        logic                               changed;
    } t_stack_result;

    // Mirror of the stacking order plus the queue of results still owed.
    class t_stack_board;
        logic [zors_pkg::ID_W-1:0] order [N_SURF];
        int                        depth;
        t_stack_result             due [$];
        int unsigned               mismatches;
        int unsigned               n_raise, n_remove, n_query, n_full_drops, n_empty_hits;

        function new();
            foreach (order[i]) order[i] = '0;
            depth        = 0;
            mismatches   = 0;
            n_raise      = 0;
            n_remove     = 0;
            n_query      = 0;
            n_full_drops = 0;
            n_empty_hits = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Position among the live entries only; cleared slots above never match.
        function int locate(logic [zors_pkg::ID_W-1:0] id);
            for (int i = 0; i < depth; i++) begin
                if (order[i] == id) return i;
            end
            return -1;
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < depth; i++) order[i] = order[i + 1];
            depth--;
            order[depth] = '0;
        endfunction

        // Apply one accepted beat and queue the result it owes.
        function void note_beat(logic [zors_pkg::CMD_W-1:0] cmd,
                                logic [zors_pkg::ID_W-1:0] id);
            int            rank;
            t_stack_result r;
            rank      = locate(id);
            r.changed = 1'b0;
            if (depth == 0) n_empty_hits++;
            if (cmd == zors_pkg::CMD_REMOVE) begin
                n_remove++;
                if (rank >= 0) begin
                    drop_at(rank);
                    r.changed = 1'b1;
                end
            end else if (cmd == zors_pkg::CMD_RAISE) begin
                n_raise++;
                if (!(rank >= 0 && rank == depth - 1)) begin
                    if (rank >= 0) begin
                        drop_at(rank);
                        r.changed = 1'b1;
                    end
                    if (depth < N_SURF) begin
                        order[depth] = id;
                        depth++;
                        r.changed = 1'b1;
                    end else begin
                        n_full_drops++;
                    end
                end
            end else begin
                n_query++;
            end
            r.rank_before = rank[zors_pkg::RANK_W-1:0];
            r.count_after = depth[zors_pkg::COUNT_W-1:0];
            due.push_back(r);
        endfunction

        function void check_result(logic signed [zors_pkg::RANK_W-1:0] rank_before,
                                   logic [zors_pkg::COUNT_W-1:0] count_after,
                                   logic changed);
            t_stack_result want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result rank %0d count %0d changed %0b",
                             rank_before, count_after, changed);
                return;
            end
            want = due.pop_front();
            if (rank_before !== want.rank_before || count_after !== want.count_after ||
                changed !== want.changed) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: %0t expected rank %0d count %0d changed %0b",
                             $realtime, want.rank_before, want.count_after, want.changed);
                    $display("       got rank %0d count %0d changed %0b",
                             rank_before, count_after, changed);
                end
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [zors_pkg::CMD_W-1:0]          i_cmd;
    logic [zors_pkg::ID_W-1:0]           i_surface_id;
    logic                                o_done;
    logic signed [zors_pkg::RANK_W-1:0]  o_rank_before;
    logic [zors_pkg::COUNT_W-1:0]        o_count_after;
    logic                                o_changed;

    t_stack_board              board = new();
    logic [zors_pkg::ID_W-1:0] id_pool [POOL_SIZE];
    int                        stall_cycles;

    z_order_raise_stack #(
        .MAX_SURFACES(N_SURF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_surface_id  (i_surface_id),
        .o_done        (o_done),
        .o_rank_before (o_rank_before),
        .o_count_after (o_count_after),
        .o_changed     (o_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Present one beat and hold it until the edge that accepts it. Leave start
    // high on return: the caller either idles or presents the next beat.
    task automatic send_beat(input logic [zors_pkg::CMD_W-1:0] cmd,
                             input logic [zors_pkg::ID_W-1:0] id);
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_surface_id <= id;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_beat(cmd, id);
    endtask

    // Drop start while idling; scramble the payload to show it is ignored.
    task automatic idle_cycles(input int n);
        start        <= 1'b0;
        i_cmd        <= 2'($urandom_range(0, 3));
        i_surface_id <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        if (board.pending() != 0) begin
            start <= 1'b0;
            while (board.pending() != 0) @(posedge i_clk);
        end
    endtask

    // Mostly pool identities so the list sees repeats; the rest are fully random.
    function automatic logic [zors_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [zors_pkg::CMD_W-1:0] pick_cmd(input int raise_pct);
        int roll;
        if ($urandom_range(0, 99) < raise_pct) return zors_pkg::CMD_RAISE;
        roll = $urandom_range(0, 9);
        if (roll < 6) return zors_pkg::CMD_REMOVE;
        if (roll < 9) return zors_pkg::CMD_QUERY;
        return CMD_SPARE;
    endfunction

    // Check every strobed result on the edge that ends its cycle, and watch for
    // a hang: count cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            board.check_result(o_rank_before, o_count_after, o_changed);
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results owed",
                     STALL_MAX, board.pending());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int raise_pct;
        bit calm;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_cmd        <= zors_pkg::CMD_QUERY;
        i_surface_id <= '0;
        stall_cycles <= 0;
        raise_pct    = 45;
        // Keep both identity extremes in the pool.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: query and remove miss, raise inserts.
        send_beat(zors_pkg::CMD_QUERY,  32'd5);
        send_beat(zors_pkg::CMD_REMOVE, 32'd5);
        send_beat(zors_pkg::CMD_RAISE,  32'hFFFF_FFFF);
        // Already on top: no change.
        send_beat(zors_pkg::CMD_RAISE,  32'hFFFF_FFFF);
        // Identity zero behaves like any other surface.
        send_beat(zors_pkg::CMD_RAISE,  32'h0000_0000);
        send_beat(CMD_SPARE,            32'h0000_0000);
        // Fill to capacity.
        for (int k = 1; k <= N_SURF - 2; k++) send_beat(zors_pkg::CMD_RAISE, 32'(k));
        // Full list: drop an absent surface, move a present one from the bottom.
        send_beat(zors_pkg::CMD_RAISE,  32'h5555_AAAA);
        send_beat(zors_pkg::CMD_RAISE,  32'hFFFF_FFFF);
        // Remove in the middle, at the top and at the bottom.
        send_beat(zors_pkg::CMD_REMOVE, 32'd7);
        send_beat(zors_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
        send_beat(zors_pkg::CMD_REMOVE, 32'h0000_0000);
        // Cleared slots above the top must not match identity zero.
        send_beat(zors_pkg::CMD_QUERY,  32'h0000_0000);
        send_beat(zors_pkg::CMD_RAISE,  32'(N_SURF - 2));
        drain_results();

        // Random traffic: vary the raise share per block so the list both
        // fills and empties; keep a long stretch free of idle gaps.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) raise_pct = $urandom_range(25, 65);
            calm = (n >= 500 && n < 800);
            if (!calm && $urandom_range(0, 99) < 7) idle_cycles($urandom_range(1, 3));
            if (n % 350 == 349) drain_results();
            send_beat(pick_cmd(raise_pct), pick_id());
        end
        start <= 1'b0;

        // Wait for the last results, then let the pipeline settle.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d raises, %0d removes and %0d rank queries (spare code included).",
                 board.n_raise, board.n_remove, board.n_query);
        $display("%0d beats hit an empty list, %0d raises were dropped on a full one;",
                 board.n_empty_hits, board.n_full_drops);
        $display("%0d mismatches.", board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/zors_pkg.sv
sv/zors_cell.sv
sv/zors_rank.sv
sv/z_order_raise_stack.sv
test/tb_top.sv
